### sv/blf_pkg.sv
package blf_pkg;

  localparam int CMD_W = 5;

  localparam logic [CMD_W-1:0] CMD_NONE       = 5'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD       = 5'd1;
  localparam logic [CMD_W-1:0] CMD_MUL_G      = 5'd2;
  localparam logic [CMD_W-1:0] CMD_MUL_C0     = 5'd3;
  localparam logic [CMD_W-1:0] CMD_MUL_C1     = 5'd4;
  localparam logic [CMD_W-1:0] CMD_EMIT       = 5'd5;
  localparam logic [CMD_W-1:0] CMD_DIV_ALPHA  = 5'd6;
  localparam logic [CMD_W-1:0] CMD_TAKE_ALPHA = 5'd7;
  localparam logic [CMD_W-1:0] CMD_SCALE      = 5'd8;
  localparam logic [CMD_W-1:0] CMD_WARP       = 5'd9;
  localparam logic [CMD_W-1:0] CMD_K2         = 5'd10;
  localparam logic [CMD_W-1:0] CMD_DEN        = 5'd11;
  localparam logic [CMD_W-1:0] CMD_DIV_A      = 5'd12;
  localparam logic [CMD_W-1:0] CMD_TAKE_A     = 5'd13;
  localparam logic [CMD_W-1:0] CMD_DIV_IK2    = 5'd14;
  localparam logic [CMD_W-1:0] CMD_TAKE_IK2   = 5'd15;
  localparam logic [CMD_W-1:0] CMD_B1         = 5'd16;
  localparam logic [CMD_W-1:0] CMD_FINISH     = 5'd17;

  localparam int DVD_W = 64;
  localparam int DSR_W = 36;

  localparam logic [8:0]  DELAY_RESET = 9'd2;
  localparam logic [8:0]  DELAY_MIN   = 9'd2;
  localparam logic [63:0] HALF_Q24    = 64'd1 << 23;
  localparam logic [63:0] ONE_Q24     = 64'd1 << 24;
  localparam logic [63:0] ONE_Q48     = 64'd1 << 48;
  localparam logic [4:0]  WARP_IDX_MAX = 5'd16;

  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             div_start;
  } blf_cmd_t;

  typedef struct packed {
    logic div_done;
  } blf_stat_t;

  // Rough Q12 tangent table for frequency warping
  function automatic logic [15:0] tan_q12(input logic [4:0] idx);
    logic [15:0] t;
    unique case (idx)
      5'd0:  t = 16'd0;
      5'd1:  t = 16'd358;
      5'd2:  t = 16'd722;
      5'd3:  t = 16'd1098;
      5'd4:  t = 16'd1491;
      5'd5:  t = 16'd1910;
      5'd6:  t = 16'd2365;
      5'd7:  t = 16'd2868;
      5'd8:  t = 16'd3437;
      5'd9:  t = 16'd4096;
      5'd10: t = 16'd4881;
      5'd11: t = 16'd5850;
      5'd12: t = 16'd7094;
      5'd13: t = 16'd8784;
      5'd14: t = 16'd11254;
      5'd15: t = 16'd15286;
      5'd16: t = 16'd23230;
      5'd17: t = 16'd46817;
      default: t = 16'd0;
    endcase
    return t;
  endfunction

endpackage

### sv/bessel_lowpass_follower_core.sv
// Sample item: the load, the three products taken in turn on the shared multiplier
// and the write-back of the result, which waits while out_stall holds the output;
// a new item is taken only once the write-back is done.
// Restart item: three 64-step divisions run one quotient bit per cycle through the
// shared divider; no result item.
// Reset (rst, synchronous): history and coefficients to zero, delay_frames to 2,
// no result pending.
module bessel_lowpass_follower_core import blf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // configuration: time constant in items
  input  logic               delay_frames_wr_en,
  input  logic [8:0]         delay_frames,
  // input items
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic signed [31:0] value,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] filtered
);

  blf_cmd_t  cmd;
  blf_stat_t stat;

  // Sequence the sample products and the coefficient derivation
  blf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold history, coefficients, the divider and the output register
  blf_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (delay_frames_wr_en),
    .cfg_data (delay_frames),
    .value    (value),
    .cmd      (cmd),
    .stat     (stat),
    .filtered (filtered)
  );

endmodule

### sv/blf_div.sv
module blf_div import blf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  logic             busy;
  logic [5:0]       cnt;
  logic [DVD_W-1:0] dvd;
  logic [DSR_W-1:0] dsr;
  logic [DSR_W-1:0] rem;
  logic [DSR_W:0]   rem_sh;

  assign rem_sh   = {rem, dvd[DVD_W-1]};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      if (rem_sh >= {1'b0, dsr}) begin
        rem <= DSR_W'(rem_sh - {1'b0, dsr});
        dvd <= {dvd[DVD_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DSR_W-1:0];
        dvd <= {dvd[DVD_W-2:0], 1'b0};
      end
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy) else $error("divider done without a run");
  a_busy_ends: assert property (@(posedge clk) disable iff (rst)
    (busy && !start) |=> (busy || done)) else $error("divider run lost");

endmodule

### sv/blf_dp.sv
module blf_dp import blf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [8:0]         cfg_data,
  input  logic signed [31:0] value,
  input  blf_cmd_t           cmd,
  output blf_stat_t          stat,
  output logic signed [63:0] filtered
);

  logic [8:0]         delay_frames;
  logic signed [31:0] x_val;
  logic signed [31:0] in_hist_1, in_hist_2, out_hist_1, out_hist_2;
  logic signed [31:0] feedback_coef_1, feedback_coef_2, input_gain;
  logic [63:0]        acc, prod;
  logic [23:0]        alpha;
  logic [29:0]        scaled;
  logic [16:0]        warp;
  logic [18:0]        k1;
  logic [33:0]        k2;
  logic [35:0]        den;
  logic [24:0]        a_q;
  logic [37:0]        ik2;
  logic [63:0]        b1;

  logic [8:0]         d_eff;
  logic [DVD_W-1:0]   div_dvd, div_quo;
  logic [DSR_W-1:0]   div_dsr;
  logic               div_done;

  logic signed [33:0] tap_sum, mul_a;
  logic signed [31:0] mul_b;
  logic signed [65:0] mul_p;
  logic [63:0]        emit_sum, ya;
  logic [4:0]         widx;
  logic [25:0]        frac;
  logic [15:0]        t0, t1;
  logic [41:0]        slope;
  logic signed [39:0] ik_off;
  logic signed [26:0] a_twice;
  logic signed [66:0] b1_p;
  logic [63:0]        b2, r1, r2;

  assign d_eff = (delay_frames < DELAY_MIN) ? DELAY_MIN : delay_frames;

  always_comb begin
    unique case (cmd.op)
      CMD_DIV_ALPHA: begin
        div_dvd = ONE_Q24;
        div_dsr = DSR_W'(d_eff);
      end
      CMD_DIV_A: begin
        div_dvd = {6'd0, k2, 24'd0};
        div_dsr = den;
      end
      default: begin
        div_dvd = ONE_Q48;
        div_dsr = {2'd0, k2};
      end
    endcase
  end

  blf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign stat.div_done = div_done;

  // sample path
  assign tap_sum = {{2{x_val[31]}}, x_val} + ({{2{in_hist_1[31]}}, in_hist_1} <<< 1)
                 + {{2{in_hist_2[31]}}, in_hist_2};

  always_comb begin
    unique case (cmd.op)
      CMD_MUL_C0: begin
        mul_a = {{2{out_hist_1[31]}}, out_hist_1};
        mul_b = feedback_coef_1;
      end
      CMD_MUL_C1: begin
        mul_a = {{2{out_hist_2[31]}}, out_hist_2};
        mul_b = feedback_coef_2;
      end
      default: begin
        mul_a = tap_sum;
        mul_b = input_gain;
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign emit_sum = acc + prod + HALF_Q24;
  assign ya       = 64'($signed(emit_sum) >>> 24);

  // coefficient path
  assign widx  = (scaled[29:24] > {1'b0, WARP_IDX_MAX}) ? WARP_IDX_MAX : scaled[28:24];
  assign frac  = 26'(scaled - {1'b0, widx, 24'd0});
  assign t0    = tan_q12(widx);
  assign t1    = tan_q12(widx + 5'd1);
  assign slope = {26'd0, t1 - t0} * {16'd0, frac};

  assign ik_off  = $signed({2'b00, ik2}) - 40'sd16777216;
  assign a_twice = $signed({1'b0, a_q, 1'b0});
  assign b1_p    = a_twice * ik_off;
  assign b2      = ONE_Q48 - {13'd0, a_q, 26'd0} - b1;
  assign r1      = b1 + HALF_Q24;
  assign r2      = b2 + HALF_Q24;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_frames <= DELAY_RESET;
    end else if (cfg_we) begin
      delay_frames <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_hist_1       <= '0;
      in_hist_2       <= '0;
      out_hist_1      <= '0;
      out_hist_2      <= '0;
      feedback_coef_1 <= '0;
      feedback_coef_2 <= '0;
      input_gain      <= '0;
    end else if (cmd.op == CMD_EMIT) begin
      in_hist_2  <= in_hist_1;
      in_hist_1  <= x_val;
      out_hist_2 <= out_hist_1;
      out_hist_1 <= ya[31:0];
    end else if (cmd.op == CMD_FINISH) begin
      feedback_coef_1 <= r1[55:24];
      feedback_coef_2 <= r2[55:24];
      input_gain      <= {7'd0, a_q};
      in_hist_1       <= x_val;
      in_hist_2       <= x_val;
      out_hist_1      <= x_val;
      out_hist_2      <= x_val;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CMD_LOAD:       x_val <= value;
      CMD_MUL_G:      prod <= mul_p[63:0];
      CMD_MUL_C0: begin
        acc  <= prod;
        prod <= mul_p[63:0];
      end
      CMD_MUL_C1: begin
        acc  <= acc + prod;
        prod <= mul_p[63:0];
      end
      CMD_EMIT:       filtered <= ya;
      CMD_TAKE_ALPHA: alpha <= div_quo[23:0];
      CMD_SCALE:      scaled <= 30'(alpha) * 30'd36;
      CMD_WARP:       warp <= 17'(t0) + slope[40:24];
      CMD_K2: begin
        k1 <= 19'(warp) * 19'd3;
        k2 <= 34'((19'(warp) * 19'd3) * 34'(warp));
      end
      CMD_DEN:        den <= 36'({k1 + 19'd4096, 12'd0}) + 36'(k2);
      CMD_TAKE_A:     a_q <= div_quo[24:0];
      CMD_TAKE_IK2:   ik2 <= div_quo[37:0];
      CMD_B1:         b1 <= b1_p[63:0];
      default: ;
    endcase
  end

endmodule

### sv/blf_ctrl.sv
module blf_ctrl import blf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      opcode,
  output logic      out_valid,
  input  logic      out_stall,
  input  blf_stat_t stat,
  output blf_cmd_t  cmd
);

  localparam logic [4:0] S_IDLE       = 5'd0;
  localparam logic [4:0] S_MUL_G      = 5'd1;
  localparam logic [4:0] S_MUL_C0     = 5'd2;
  localparam logic [4:0] S_MUL_C1     = 5'd3;
  localparam logic [4:0] S_EMIT       = 5'd4;
  localparam logic [4:0] S_ALPHA_GO   = 5'd5;
  localparam logic [4:0] S_ALPHA_WAIT = 5'd6;
  localparam logic [4:0] S_SCALE      = 5'd7;
  localparam logic [4:0] S_WARP       = 5'd8;
  localparam logic [4:0] S_K2         = 5'd9;
  localparam logic [4:0] S_DEN        = 5'd10;
  localparam logic [4:0] S_A_GO       = 5'd11;
  localparam logic [4:0] S_A_WAIT     = 5'd12;
  localparam logic [4:0] S_IK_GO      = 5'd13;
  localparam logic [4:0] S_IK_WAIT    = 5'd14;
  localparam logic [4:0] S_B1         = 5'd15;
  localparam logic [4:0] S_FIN        = 5'd16;

  logic [4:0] state, state_next;
  logic       in_take, out_free;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next    = state;
    cmd.op        = CMD_NONE;
    cmd.div_start = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_take) begin
          cmd.op     = CMD_LOAD;
          state_next = opcode ? S_ALPHA_GO : S_MUL_G;
        end
      end
      S_MUL_G: begin
        cmd.op = CMD_MUL_G;
        state_next = S_MUL_C0;
      end
      S_MUL_C0: begin
        cmd.op = CMD_MUL_C0;
        state_next = S_MUL_C1;
      end
      S_MUL_C1: begin
        cmd.op = CMD_MUL_C1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.op     = CMD_EMIT;
          state_next = S_IDLE;
        end
      end
      S_ALPHA_GO: begin
        cmd.op        = CMD_DIV_ALPHA;
        cmd.div_start = 1'b1;
        state_next    = S_ALPHA_WAIT;
      end
      S_ALPHA_WAIT: begin
        if (stat.div_done) begin
          cmd.op     = CMD_TAKE_ALPHA;
          state_next = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.op = CMD_SCALE;
        state_next = S_WARP;
      end
      S_WARP: begin
        cmd.op = CMD_WARP;
        state_next = S_K2;
      end
      S_K2: begin
        cmd.op = CMD_K2;
        state_next = S_DEN;
      end
      S_DEN: begin
        cmd.op = CMD_DEN;
        state_next = S_A_GO;
      end
      S_A_GO: begin
        cmd.op        = CMD_DIV_A;
        cmd.div_start = 1'b1;
        state_next    = S_A_WAIT;
      end
      S_A_WAIT: begin
        if (stat.div_done) begin
          cmd.op     = CMD_TAKE_A;
          state_next = S_IK_GO;
        end
      end
      S_IK_GO: begin
        cmd.op        = CMD_DIV_IK2;
        cmd.div_start = 1'b1;
        state_next    = S_IK_WAIT;
      end
      S_IK_WAIT: begin
        if (stat.div_done) begin
          cmd.op     = CMD_TAKE_IK2;
          state_next = S_B1;
        end
      end
      S_B1: begin
        cmd.op = CMD_B1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.op = CMD_FINISH;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!out_valid && state == S_IDLE)) else $error("not idle after reset");
  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free) |=> out_valid) else $error("result not shown");
  a_sample_path: assert property (@(posedge clk) disable iff (rst)
    (in_take && !opcode) |=> state == S_MUL_G) else $error("sample not started");
  a_restart_path: assert property (@(posedge clk) disable iff (rst)
    (in_take && opcode) |=> state == S_ALPHA_GO) else $error("restart not started");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench import blf_pkg::*;;

  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;
  // a restart gives no result; allow time for any restart still running to finish
  localparam int RESTART_SETTLE = 400;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               delay_frames_wr_en = 1'b0;
  logic [8:0]         delay_frames = DELAY_RESET;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               opcode = OP_SAMPLE;
  logic signed [31:0] value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [63:0] filtered;

  bessel_lowpass_follower_core u_top (
    .clk(clk), .rst(rst),
    .delay_frames_wr_en(delay_frames_wr_en), .delay_frames(delay_frames),
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .value(value),
    .out_valid(out_valid), .out_stall(out_stall), .filtered(filtered)
  );

  always #5 clk = ~clk;

  // shadow copy of the filter state
  logic [8:0]  sh_delay;
  logic [31:0] sh_x0, sh_x1, sh_y0, sh_y1, sh_c0, sh_c1, sh_g;
  longint      filtered_due[$];
  int          errors = 0;
  bit          calm = 1'b0;   // when set, neither side idles

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic longint tan_lut(input longint i);
    case (i)
      0: return 0;        1: return 358;      2: return 722;      3: return 1098;
      4: return 1491;     5: return 1910;     6: return 2365;     7: return 2868;
      8: return 3437;     9: return 4096;     10: return 4881;    11: return 5850;
      12: return 7094;    13: return 8784;    14: return 11254;   15: return 15286;
      16: return 23230;   default: return 46817;
    endcase
  endfunction

  // warp alpha through the coarse tangent table, linear interpolation
  function automatic longint warp_of(input longint alpha);
    longint scaled, idx, t0, t1, frac;
    scaled = alpha * 36;
    idx = scaled >>> 24;
    if (idx >= 17) idx = 16;
    t0 = tan_lut(idx);
    t1 = tan_lut(idx + 1);
    frac = scaled - (idx <<< 24);
    return ((t0 <<< 32) + ((t1 - t0) <<< 8) * frac) >>> 32;
  endfunction

  // derive the coefficients from the delay and preload the histories
  task automatic coefs_restart(input logic [31:0] v);
    longint d, alpha, warp, k1, k2, den, a, ik2, b1, b2, one48;
    one48 = longint'(1) <<< 48;
    d = longint'(sh_delay);
    if (d < 2) d = 2;
    alpha = (longint'(1) <<< 24) / d;
    warp = warp_of(alpha);
    k1 = 3 * warp;
    k2 = k1 * warp;
    den = ((longint'(4096) + k1) <<< 12) + k2;
    a = (k2 <<< 24) / den;
    ik2 = one48 / k2;
    b1 = 2 * a * (ik2 - (longint'(1) <<< 24));
    b2 = one48 - ((4 * a) <<< 24) - b1;
    sh_c0 = 32'((b1 + (longint'(1) <<< 23)) >>> 24);
    sh_c1 = 32'((b2 + (longint'(1) <<< 23)) >>> 24);
    sh_g = 32'(a);
    sh_x0 = v; sh_x1 = v; sh_y0 = v; sh_y1 = v;
  endtask

  // one filter step; products wrap at 64 bits
  function automatic longint filter_step(input logic [31:0] v);
    longint acc, ya;
    acc = (longint'($signed(v)) + 2 * longint'($signed(sh_x0)) + longint'($signed(sh_x1)))
          * longint'($signed(sh_g));
    acc += longint'($signed(sh_y0)) * longint'($signed(sh_c0));
    acc += longint'($signed(sh_y1)) * longint'($signed(sh_c1));
    acc += longint'(1) <<< 23;
    ya = acc >>> 24;
    sh_x1 = sh_x0; sh_x0 = v;
    sh_y1 = sh_y0; sh_y0 = 32'(ya);
    return ya;
  endfunction

  // check every result item against the oldest expectation
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 9);
    if (!rst && out_valid && !out_stall) begin
      if (filtered_due.size() == 0) begin
        report_mismatch($sformatf("unexpected item filtered=%0d", filtered));
      end else begin
        if (filtered !== filtered_due[0])
          report_mismatch($sformatf("filtered got %0d want %0d", filtered, filtered_due[0]));
        void'(filtered_due.pop_front());
      end
    end
  end

  // send one item; hold valid and payload until accepted
  task automatic send_item(input logic op, input logic [31:0] v);
    if (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    value    <= v;
    do @(posedge clk); while (in_stall);
    if (op == OP_RESTART) coefs_restart(v);
    else filtered_due.push_back(filter_step(v));
  endtask

  // wait for every expected item, then for any restart still running
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (filtered_due.size() != 0) @(posedge clk);
    repeat (RESTART_SETTLE) @(posedge clk);
  endtask

  task automatic set_delay(input logic [8:0] d);
    delay_frames_wr_en <= 1'b1;
    delay_frames       <= d;
    @(posedge clk);
    delay_frames_wr_en <= 1'b0;
    sh_delay = d;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF - $urandom_range(3);
      1: return 32'h8000_0000 + $urandom_range(3);
      2: return 32'($signed($urandom_range(32'h0200_0000))) - 32'h0100_0000;
      3: return 32'($urandom_range(1 << 26));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [8:0] rand_delay();
    case ($urandom_range(4))
      0: return 9'd2;
      1: return 9'd256;
      2: return 9'($urandom_range(2, 20));
      default: return 9'($urandom);
    endcase
  endfunction

  // samples before any restart must give zero
  task automatic test_unprimed();
    send_item(OP_SAMPLE, 32'h7FFF_FFFF);
    send_item(OP_SAMPLE, 32'h8000_0000);
    send_item(OP_SAMPLE, 32'h0100_0000);
    drain();   // pause until every expected item has come
  endtask

  // field extremes and the short, long and wide delay cases
  task automatic test_directed();
    logic [8:0] dl[6] = '{9'd2, 9'd0, 9'd1, 9'd256, 9'd257, 9'd511};
    foreach (dl[i]) begin
      set_delay(dl[i]);
      send_item(OP_RESTART, (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF);
      send_item(OP_SAMPLE, 32'h7FFF_FFFF);
      send_item(OP_SAMPLE, 32'h8000_0000);
      if (i < 2) send_item(OP_SAMPLE, 32'hFFFF_FFFF);
      drain();
    end
  endtask

  // random phases: each picks a delay, restarts, then streams samples
  task automatic test_random();
    for (int ph = 0; ph < 10; ph++) begin
      calm = (ph == 1);   // one phase with no idling at all
      set_delay(ph == 0 ? 9'd256 : rand_delay());
      send_item(OP_RESTART, rand_value());
      for (int n = 0; n < 150; n++) begin
        if ($urandom_range(99) < 3) send_item(OP_RESTART, rand_value());
        else send_item(OP_SAMPLE, rand_value());
      end
      drain();
    end
    calm = 1'b0;
  endtask

  initial begin
    sh_delay = DELAY_RESET;
    {sh_x0, sh_x1, sh_y0, sh_y1, sh_c0, sh_c1, sh_g} = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_unprimed();
    test_directed();
    test_random();
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### bessel_lowpass_follower_core.f
sv/blf_pkg.sv
sv/blf_div.sv
sv/blf_dp.sv
sv/blf_ctrl.sv
sv/bessel_lowpass_follower_core.sv
tb/testbench.sv
